// ----- hw/rtl/sha1_pkg.sv -----
`default_nettype none

package sha1_pkg;

    typedef enum logic [1:0] {
        OP_ADD_BYTE    = 2'd0,
        OP_READ_DIGEST = 2'd1,
        OP_RESTART     = 2'd2
    } sha1_op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ROUND = 2'd1,
        ST_ADD   = 2'd2,
        ST_EMIT  = 2'd3
    } sha1_state_t;

    // Source of the schedule words for the block being compressed
    typedef enum logic [1:0] {
        MODE_MSG        = 2'd0,
        MODE_PAD_FIRST  = 2'd1,
        MODE_PAD_SECOND = 2'd2
    } blk_mode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } sha1_cmd_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } sha1_res_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] idx;
    } round_ctrl_t;

    typedef struct packed {
        logic       en;
        logic [5:0] pos;
        logic [7:0] data;
    } buf_wr_t;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // IV[0] is the first chaining word
    localparam logic [4:0][31:0] IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] PAD_LIMIT  = 6'd56;
    localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

`default_nettype wire

// ----- hw/rtl/sha1_round.sv -----
`default_nettype none

module sha1_round (
    input  wire logic                    clk,
    input  wire sha1_pkg::round_ctrl_t   ctrl,
    input  wire logic [4:0][31:0]        base,
    input  wire logic [31:0]             msg_word,
    output logic [4:0][31:0]             vars
);

    logic [4:0][31:0]  vars_reg;
    logic [15:0][31:0] sched_reg;

    logic [31:0] a_w;
    logic [31:0] b_w;
    logic [31:0] c_w;
    logic [31:0] d_w;
    logic [31:0] e_w;
    logic [31:0] f_w;
    logic [31:0] k_w;
    logic [31:0] w_w;
    logic [31:0] x_w;
    logic [31:0] t_w;

    always_comb
    begin
        a_w = vars_reg[0];
        b_w = vars_reg[1];
        c_w = vars_reg[2];
        d_w = vars_reg[3];
        e_w = vars_reg[4];

        // taps w[t-3], w[t-8], w[t-14], w[t-16]
        x_w = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        if (ctrl.idx < 7'd16)
            w_w = msg_word;
        else
            w_w = {x_w[30:0], x_w[31]};

        if (ctrl.idx inside {[7'd0:7'd19]})
        begin
            f_w = (b_w & c_w) | (~b_w & d_w);
            k_w = sha1_pkg::K_0;
        end
        else if (ctrl.idx inside {[7'd20:7'd39]})
        begin
            f_w = b_w ^ c_w ^ d_w;
            k_w = sha1_pkg::K_1;
        end
        else if (ctrl.idx inside {[7'd40:7'd59]})
        begin
            f_w = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            k_w = sha1_pkg::K_2;
        end
        else
        begin
            f_w = b_w ^ c_w ^ d_w;
            k_w = sha1_pkg::K_3;
        end

        t_w = {a_w[26:0], a_w[31:27]} + f_w + e_w + k_w + w_w;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            vars_reg <= base;
        end
        else if (ctrl.step)
        begin
            vars_reg  <= {d_w, c_w, {b_w[1:0], b_w[31:2]}, a_w, t_w};
            sched_reg <= {w_w, sched_reg[15:1]};
        end
    end

    assign vars = vars_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sha1_msg_buf.sv -----
`default_nettype none

module sha1_msg_buf (
    input  wire logic                  clk,
    input  wire sha1_pkg::buf_wr_t     wr,
    input  wire sha1_pkg::blk_mode_t   mode,
    input  wire logic [3:0]            idx,
    input  wire logic [5:0]            fill,
    input  wire logic [63:0]           bit_len,
    output logic [31:0]                word
);

    logic [23:0] acc_reg;
    logic [31:0] words_reg [16];

    logic [3:0]  q_w;
    logic [31:0] part_w;
    logic [31:0] len_w;
    logic        len_hit_w;
    logic        single_w;

    // gather three bytes, write the word on the fourth
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            case (wr.pos[1:0])
                2'd0:    acc_reg[23:16] <= wr.data;
                2'd1:    acc_reg[15:8]  <= wr.data;
                2'd2:    acc_reg[7:0]   <= wr.data;
                default: words_reg[wr.pos[5:2]] <= {acc_reg, wr.data};
            endcase
        end
    end

    always_comb
    begin
        q_w       = fill[5:2];
        single_w  = (fill < sha1_pkg::PAD_LIMIT);
        len_hit_w = (idx == 4'd14) || (idx == 4'd15);
        len_w     = idx[0] ? bit_len[31:0] : bit_len[63:32];

        // partial word: held bytes, then the pad marker, then zeros
        case (fill[1:0])
            2'd0:    part_w = {sha1_pkg::PAD_BYTE, 24'h0};
            2'd1:    part_w = {acc_reg[23:16], sha1_pkg::PAD_BYTE, 16'h0};
            2'd2:    part_w = {acc_reg[23:8], sha1_pkg::PAD_BYTE, 8'h0};
            default: part_w = {acc_reg, sha1_pkg::PAD_BYTE};
        endcase

        case (mode)
            sha1_pkg::MODE_MSG:
                word = words_reg[idx];
            sha1_pkg::MODE_PAD_FIRST:
            begin
                if (idx < q_w)
                    word = words_reg[idx];
                else if (idx == q_w)
                    word = part_w;
                else if (single_w && len_hit_w)
                    word = len_w;
                else
                    word = 32'h0;
            end
            sha1_pkg::MODE_PAD_SECOND:
                word = len_hit_w ? len_w : 32'h0;
            default:
                word = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sha1_stream_hasher_core.sv -----
// add_byte: taken without a stall while idle; the 64th byte of a block stalls the command
//   channel through the rounds of the shared round unit and the final add.
// read_digest: rounds and add for one padding block, or for two when padding spills into
//   a second block, then five result beats, one per cycle when not stalled.
// restart and unused codes do not stall the command channel.
// Reset loads the initial vector and clears the byte counters and all handshakes.
`default_nettype none

module sha1_stream_hasher_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire sha1_pkg::sha1_cmd_t  cmd_data,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output sha1_pkg::sha1_res_t       res_data
);

    sha1_pkg::sha1_state_t state_reg, state_next;
    sha1_pkg::blk_mode_t   mode_reg, mode_next;
    logic [6:0]            round_reg, round_next;
    logic [4:0][31:0]      hash_reg, hash_next;
    logic [4:0][31:0]      dig_reg, dig_next;
    logic [5:0]            fill_reg, fill_next;
    logic [60:0]           total_reg, total_next;
    logic [2:0]            emit_reg, emit_next;
    logic                  res_valid_reg, res_valid_next;
    sha1_pkg::sha1_res_t   res_data_reg, res_data_next;

    sha1_pkg::round_ctrl_t rctrl_w;
    sha1_pkg::buf_wr_t     wr_w;
    logic [4:0][31:0]      base_w;
    logic [4:0][31:0]      vars_w;
    logic [4:0][31:0]      sum_w;
    logic [31:0]           msg_word_w;
    logic                  cmd_fire_w;
    logic                  res_fire_w;

    sha1_round u_round (
        .clk      (clk),
        .ctrl     (rctrl_w),
        .base     (base_w),
        .msg_word (msg_word_w),
        .vars     (vars_w)
    );

    sha1_msg_buf u_buf (
        .clk     (clk),
        .wr      (wr_w),
        .mode    (mode_reg),
        .idx     (round_reg[3:0]),
        .fill    (fill_reg),
        .bit_len ({total_reg, 3'b000}),
        .word    (msg_word_w)
    );

    assign cmd_stall  = (state_reg != sha1_pkg::ST_IDLE);
    assign cmd_fire_w = cmd_valid && !cmd_stall;
    assign res_fire_w = res_valid_reg && !res_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (mode_reg == sha1_pkg::MODE_PAD_SECOND)
                sum_w[i] = dig_reg[i] + vars_w[i];
            else
                sum_w[i] = hash_reg[i] + vars_w[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        round_next     = round_reg;
        hash_next      = hash_reg;
        dig_next       = dig_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        emit_next      = emit_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rctrl_w.load   = 1'b0;
        rctrl_w.step   = 1'b0;
        rctrl_w.idx    = round_reg;
        wr_w.en        = 1'b0;
        wr_w.pos       = fill_reg;
        wr_w.data      = cmd_data.data_byte;
        base_w         = hash_reg;

        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (cmd_fire_w)
                begin
                    case (cmd_data.operation)
                        sha1_pkg::OP_ADD_BYTE:
                        begin
                            wr_w.en    = 1'b1;
                            fill_next  = fill_reg + 6'd1;
                            total_next = total_reg + 61'd1;
                            if (fill_reg == sha1_pkg::LAST_FILL)
                            begin
                                mode_next    = sha1_pkg::MODE_MSG;
                                rctrl_w.load = 1'b1;
                                round_next   = 7'd0;
                                state_next   = sha1_pkg::ST_ROUND;
                            end
                        end
                        sha1_pkg::OP_READ_DIGEST:
                        begin
                            mode_next    = sha1_pkg::MODE_PAD_FIRST;
                            rctrl_w.load = 1'b1;
                            round_next   = 7'd0;
                            state_next   = sha1_pkg::ST_ROUND;
                        end
                        sha1_pkg::OP_RESTART:
                        begin
                            hash_next  = sha1_pkg::IV;
                            fill_next  = 6'd0;
                            total_next = 61'd0;
                        end
                        default: ;
                    endcase
                end
            end

            sha1_pkg::ST_ROUND:
            begin
                rctrl_w.step = 1'b1;
                if (round_reg == sha1_pkg::LAST_ROUND)
                    state_next = sha1_pkg::ST_ADD;
                else
                    round_next = round_reg + 7'd1;
            end

            sha1_pkg::ST_ADD:
            begin
                case (mode_reg)
                    sha1_pkg::MODE_MSG:
                    begin
                        hash_next  = sum_w;
                        state_next = sha1_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        dig_next = sum_w;
                        // length does not fit: run a second, length-only block
                        if (mode_reg == sha1_pkg::MODE_PAD_FIRST &&
                            fill_reg >= sha1_pkg::PAD_LIMIT)
                        begin
                            mode_next    = sha1_pkg::MODE_PAD_SECOND;
                            base_w       = sum_w;
                            rctrl_w.load = 1'b1;
                            round_next   = 7'd0;
                            state_next   = sha1_pkg::ST_ROUND;
                        end
                        else
                        begin
                            emit_next                 = 3'd0;
                            res_valid_next            = 1'b1;
                            res_data_next.digest_word = sum_w[0];
                            res_data_next.word_number = 3'd0;
                            res_data_next.last_word   = 1'b0;
                            state_next                = sha1_pkg::ST_EMIT;
                        end
                    end
                endcase
            end

            sha1_pkg::ST_EMIT:
            begin
                if (res_fire_w)
                begin
                    if (emit_reg == sha1_pkg::LAST_WORD)
                    begin
                        res_valid_next = 1'b0;
                        state_next     = sha1_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit_next                 = emit_reg + 3'd1;
                        res_data_next.digest_word = dig_reg[emit_next];
                        res_data_next.word_number = emit_next;
                        res_data_next.last_word   = (emit_next == sha1_pkg::LAST_WORD);
                    end
                end
            end

            default:
                state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ST_IDLE;
            mode_reg      <= sha1_pkg::MODE_MSG;
            round_reg     <= 7'd0;
            hash_reg      <= sha1_pkg::IV;
            fill_reg      <= 6'd0;
            total_reg     <= 61'd0;
            emit_reg      <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            round_reg     <= round_next;
            hash_reg      <= hash_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            emit_reg      <= emit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg      <= dig_next;
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sha1_checker.sv -----
`default_nettype none

module sha1_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cmd_valid,
    input wire logic                 cmd_stall,
    input wire sha1_pkg::sha1_cmd_t  cmd_data,
    input wire logic                 res_valid,
    input wire logic                 res_stall,
    input wire sha1_pkg::sha1_res_t  res_data
);

    logic unused_w;
    assign unused_w = cmd_valid ^ (^cmd_data);

    // hold a stalled result beat
    a_res_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("result payload changed while stalled");

    a_no_cmd_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("command taken while digest words pending");

    a_word_advance: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res_data.last_word |=>
            res_valid && (res_data.word_number == $past(res_data.word_number) + 3'd1))
        else $error("digest word sequence broken");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res_data.last_word |=> !res_valid)
        else $error("result valid after last word");

endmodule

bind sha1_stream_hasher_core sha1_checker u_sha1_checker (.*);

`default_nettype wire

// ----- sim/sha1_digest_checker.sv -----
`timescale 1ns / 100ps

module sha1_digest_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire logic                cmd_stall,
    input  wire sha1_pkg::sha1_cmd_t cmd_data,
    input  wire logic                res_valid,
    input  wire logic                res_stall,
    input  wire sha1_pkg::sha1_res_t res_data,
    output int                       err_count,
    output int                       pending_words,
    output int                       words_checked
);

    // chaining words packed first word high: word k at [159-32k -: 32]
    logic [159:0]        chain_h;
    logic [511:0]        msg_blk;
    logic [5:0]          fill_cnt;
    logic [60:0]         msg_bytes;
    sha1_pkg::sha1_res_t digest_q[$];
    int                  fails;
    int                  seen;

    function automatic logic [159:0] sha1_block(input logic [159:0] h, input logic [511:0] blk);
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        {a, b, c, d, e} = h;
        for (i = 0; i < 80; i++)
        begin
            if (i >= 16)
            begin
                x = w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15];
                w[i & 15] = {x[30:0], x[31]};
            end
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // pad a private copy; the stored chain and buffer stay as they are
    function automatic logic [159:0] padded_digest(input logic [159:0] h_in,
                                                   input logic [511:0] blk_in,
                                                   input logic [5:0]   fill,
                                                   input logic [60:0]  nbytes);
        logic [159:0] h;
        logic [511:0] blk;
        int idx, j;
        h = h_in;
        blk = blk_in;
        idx = fill;
        blk[511 - 8 * idx -: 8] = sha1_pkg::PAD_BYTE;
        idx++;
        for (j = idx; j < 64; j++)
            blk[511 - 8 * j -: 8] = 8'h00;
        // no room for the length: spill into a second block
        if (idx > sha1_pkg::PAD_LIMIT)
        begin
            h = sha1_block(h, blk);
            blk = '0;
        end
        blk[63:0] = {nbytes, 3'b000};
        return sha1_block(h, blk);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : model
        sha1_pkg::sha1_res_t want;
        sha1_pkg::sha1_res_t got;
        logic [159:0]        h;
        int k;
        if (!rst_n)
        begin
            chain_h = {sha1_pkg::IV[0], sha1_pkg::IV[1], sha1_pkg::IV[2],
                       sha1_pkg::IV[3], sha1_pkg::IV[4]};
            msg_blk = '0;
            fill_cnt = '0;
            msg_bytes = '0;
            digest_q.delete();
            fails = 0;
            seen = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got = res_data;
                if (digest_q.size() == 0)
                begin
                    fails++;
                    $display("%0t unexpected digest beat: expected none, actual %h/%0d/%0d",
                             $time, got.digest_word, got.word_number, got.last_word);
                end
                else
                begin
                    want = digest_q.pop_front();
                    seen++;
                    if (got.digest_word !== want.digest_word)
                    begin
                        fails++;
                        $display("%0t digest_word: expected %h, actual %h",
                                 $time, want.digest_word, got.digest_word);
                    end
                    if (got.word_number !== want.word_number)
                    begin
                        fails++;
                        $display("%0t word_number: expected %0d, actual %0d",
                                 $time, want.word_number, got.word_number);
                    end
                    if (got.last_word !== want.last_word)
                    begin
                        fails++;
                        $display("%0t last_word: expected %0d, actual %0d",
                                 $time, want.last_word, got.last_word);
                    end
                end
            end

            if (cmd_valid && !cmd_stall)
            begin
                case (sha1_pkg::sha1_op_t'(cmd_data.operation))
                    sha1_pkg::OP_ADD_BYTE:
                    begin
                        msg_blk[511 - 8 * fill_cnt -: 8] = cmd_data.data_byte;
                        fill_cnt = fill_cnt + 6'd1;
                        if (fill_cnt == 6'd0)
                            chain_h = sha1_block(chain_h, msg_blk);
                        msg_bytes = msg_bytes + 61'd1;
                    end
                    sha1_pkg::OP_READ_DIGEST:
                    begin
                        h = padded_digest(chain_h, msg_blk, fill_cnt, msg_bytes);
                        for (k = 0; k < 5; k++)
                        begin
                            want.digest_word = h[159 - 32 * k -: 32];
                            want.word_number = 3'(k);
                            want.last_word = (3'(k) == sha1_pkg::LAST_WORD);
                            digest_q.push_back(want);
                        end
                    end
                    sha1_pkg::OP_RESTART:
                    begin
                        chain_h = {sha1_pkg::IV[0], sha1_pkg::IV[1], sha1_pkg::IV[2],
                                   sha1_pkg::IV[3], sha1_pkg::IV[4]};
                        fill_cnt = '0;
                        msg_bytes = '0;
                    end
                    default:
                    begin
                        // unused code: drop
                    end
                endcase
            end
        end
        err_count <= fails;
        pending_words <= digest_q.size();
        words_checked <= seen;
    end

endmodule

// ----- sim/sha1_stream_hasher_core_tb.sv -----
`timescale 1ns / 100ps

module sha1_stream_hasher_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_ITEMS  = 480;
    localparam int QUIET_FROM = 400;
    localparam int DRAIN_CYCLES = 200;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    sha1_pkg::sha1_cmd_t cmd_data;
    logic                res_valid;
    logic                res_stall;
    sha1_pkg::sha1_res_t res_data;

    int err_count;
    int pending_words;
    int words_checked;
    int items_sent;
    int reads_sent;
    bit quiet_tail;

    sha1_stream_hasher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    sha1_digest_checker digest_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd_data      (cmd_data),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_data      (res_data),
        .err_count     (err_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver side: random stall bursts, none in the tail
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !quiet_tail && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            res_stall <= 1'b0;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic push_cmd(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data.operation <= op;
        cmd_data.data_byte <= b;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
        if (op != OP_UNUSED)
            items_sent++;
        if (op == sha1_pkg::OP_READ_DIGEST)
            reads_sent++;
        if (items_sent >= QUIET_FROM)
            quiet_tail = 1'b1;
    endtask

    // one message: optional restart, bytes with reads and unused codes sprinkled in, closing read
    task automatic run_message();
        int n, j, r;
        r = $urandom_range(0, 9);
        if (r < 5)
            n = $urandom_range(0, 20);
        else if (r < 8)
            n = $urandom_range(50, 70);
        else
            n = $urandom_range(0, 140);
        if ($urandom_range(0, 3) != 0)
            push_cmd(sha1_pkg::OP_RESTART, 8'($urandom));
        for (j = 0; j < n && items_sent < NUM_ITEMS; j++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_cmd(sha1_pkg::OP_READ_DIGEST, 8'($urandom));
            if ($urandom_range(0, 40) == 0)
                push_cmd(OP_UNUSED, 8'($urandom));
            push_cmd(sha1_pkg::OP_ADD_BYTE, 8'($urandom_range(0, 255)));
        end
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        items_sent = 0;
        reads_sent = 0;
        quiet_tail = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty message, byte extremes, ignored code, short message
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'h00);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h00);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'hFF);
        push_cmd(OP_UNUSED, 8'hA5);
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'hFF);
        push_cmd(sha1_pkg::OP_RESTART, 8'h5A);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h61);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h62);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h63);
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'h00);
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'h00);
        push_cmd(sha1_pkg::OP_RESTART, 8'hFF);
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'h00);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h80);
        push_cmd(sha1_pkg::OP_ADD_BYTE, 8'h7F);
        push_cmd(OP_UNUSED, 8'h00);
        push_cmd(sha1_pkg::OP_READ_DIGEST, 8'h00);

        while (items_sent < NUM_ITEMS)
            run_message();
        cmd_valid <= 1'b0;

        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands including %0d digest reads; checked %0d digest words.",
                 items_sent, reads_sent, words_checked);
        $display("Messages spanned empty, partial, one-block and two-block padding cases.");
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_msg_buf.sv
hw/rtl/sha1_stream_hasher_core.sv
hw/rtl/sha1_checker.sv
sim/sha1_digest_checker.sv
sim/sha1_stream_hasher_core_tb.sv
